// ----- hdl/qcb_pkg.sv -----
package qcb_pkg;

    localparam int POS_W    = 15;
    localparam int COUNT_W  = 8;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [POS_W-1:0]   POS_MAX      = {POS_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] MENU_PRESSES = COUNT_W'(3);

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = CFG_W'(100);
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = CFG_W'(3000);

    typedef enum logic {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [COUNT_W-1:0] press_count;
        logic               menu_flag;
        logic               held;
        logic               clr_pos;
    } t_btn_stat;

endpackage

// ----- hdl/qcb_enc.sv -----
module qcb_enc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_pin_a,
    input  logic                       i_pin_b,
    input  logic                       i_clr,
    output logic [qcb_pkg::POS_W-1:0]  o_position
);
    import qcb_pkg::*;

    logic             r_prev_a, r_prev_b, r_a_armed, r_b_armed;
    logic             n_a_armed, n_b_armed;
    logic [POS_W-1:0] r_pos, n_pos;

    // A edge is handled before B edge, both on the current levels
    always_comb begin
        n_a_armed = r_a_armed;
        n_b_armed = r_b_armed;
        n_pos     = r_pos;
        if (i_pin_a && !r_prev_a) begin
            if (i_pin_b && n_a_armed) begin
                if (n_pos != '0) begin
                    n_pos = n_pos - POS_W'(1);
                end
                n_a_armed = 1'b0;
                n_b_armed = 1'b0;
            end else if (!i_pin_b) begin
                n_b_armed = 1'b1;
            end
        end
        if (i_pin_b && !r_prev_b) begin
            if (i_pin_a && n_b_armed) begin
                if (n_pos != POS_MAX) begin
                    n_pos = n_pos + POS_W'(1);
                end
                n_a_armed = 1'b0;
                n_b_armed = 1'b0;
            end else if (!i_pin_a) begin
                n_a_armed = 1'b1;
            end
        end
        if (i_clr) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a  <= 1'b1;
            r_prev_b  <= 1'b1;
            r_a_armed <= 1'b0;
            r_b_armed <= 1'b0;
            r_pos     <= '0;
        end else if (i_step) begin
            r_prev_a  <= i_pin_a;
            r_prev_b  <= i_pin_b;
            r_a_armed <= n_a_armed;
            r_b_armed <= n_b_armed;
            r_pos     <= n_pos;
        end
    end

    assign o_position = n_pos;

`ifndef SYNTHESIS
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_clr) |-> (n_pos == r_pos || n_pos == r_pos + POS_W'(1) ||
                                n_pos == r_pos - POS_W'(1)))
        else $error("position moved by more than one tick");
`endif

endmodule

// ----- hdl/qcb_btn.sv -----
module qcb_btn (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_button_level,
    input  logic [qcb_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [qcb_pkg::CFG_W-1:0]   i_debounce_ms,
    input  logic [qcb_pkg::CFG_W-1:0]   i_long_press_ms,
    output qcb_pkg::t_btn_stat          o_stat
);
    import qcb_pkg::*;

    logic               r_prev_btn, r_active, r_menu;
    logic               n_active, n_menu, n_clr;
    logic [TIME_W-1:0]  r_last, r_start, n_last, n_start;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [TIME_W-1:0]  w_since, w_hold;
    logic               w_pass, w_long;

    assign w_since = i_now_ms - r_last;
    assign w_hold  = i_now_ms - r_start;
    assign w_pass  = w_since > TIME_W'(i_debounce_ms);
    assign w_long  = w_hold >= TIME_W'(i_long_press_ms);

    always_comb begin
        n_active = r_active;
        n_menu   = r_menu;
        n_last   = r_last;
        n_start  = r_start;
        n_count  = r_count;
        n_clr    = 1'b0;
        if (i_button_level != r_prev_btn) begin
            if (w_pass) begin
                if (!i_button_level && !r_active) begin
                    n_active = 1'b1;
                    n_start  = i_now_ms;
                end
                n_last = i_now_ms;
            end
            // release ends the press regardless of debounce
            if (i_button_level && r_active) begin
                if (w_long) begin
                    n_clr = 1'b1;
                end else begin
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                    if (n_count >= MENU_PRESSES) begin
                        n_menu = 1'b1;
                    end
                end
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_btn <= 1'b1;
            r_active   <= 1'b0;
            r_menu     <= 1'b0;
            r_last     <= '0;
            r_start    <= '0;
            r_count    <= '0;
        end else if (i_step) begin
            r_prev_btn <= i_button_level;
            r_active   <= n_active;
            r_menu     <= n_menu;
            r_last     <= n_last;
            r_start    <= n_start;
            r_count    <= n_count;
        end
    end

    assign o_stat.press_count = n_count;
    assign o_stat.menu_flag   = n_menu;
    assign o_stat.held        = n_active;
    assign o_stat.clr_pos     = n_clr;

`ifndef SYNTHESIS
    a_menu_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_menu |=> r_menu)
        else $error("menu flag cleared");
    a_menu_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= MENU_PRESSES) |-> r_menu)
        else $error("press count reached menu threshold without menu flag");
`endif

endmodule

// ----- hdl/quadrature_counter_with_button.sv -----
// Quadrature encoder tick counter with a debounced, active-low push button.
// One sample (A, B, button level, ms timestamp) per transaction yields one
// result transaction with position, short press count, sticky menu flag and
// press-held status. The block takes one transaction per clock while the
// output is not stalled. A result passes through the input register, then
// the result register, before it is presented.
// While a result waits on a stalled output, one more sample is held in the
// input register, and further input stalls until the result is taken.
// Registers on the APB port: 0x0 debounce_ms (reset 100), 0x4 long_press_ms
// (reset 3000); write them only while no transaction is in flight.
module quadrature_counter_with_button (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_pin_a,
    input  logic                         i_pin_b,
    input  logic                         i_button_level,
    input  logic [qcb_pkg::TIME_W-1:0]   i_now_ms,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [qcb_pkg::POS_W-1:0]    o_position,
    output logic [qcb_pkg::COUNT_W-1:0]  o_press_count,
    output logic                         o_menu_flag,
    output logic                         o_held,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qcb_pkg::APB_AW-1:0]   paddr,
    input  logic [qcb_pkg::APB_DW-1:0]   pwdata,
    output logic [qcb_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import qcb_pkg::*;

    logic [CFG_W-1:0]   r_debounce, r_long_press;
    logic               r_in_valid, r_in_a, r_in_b, r_in_btn;
    logic [TIME_W-1:0]  r_in_now;
    logic               r_out_valid, r_out_menu, r_out_held;
    logic [POS_W-1:0]   r_out_pos;
    logic [COUNT_W-1:0] r_out_count;
    logic               w_move, w_cfg_wr;
    logic [POS_W-1:0]   w_pos;
    t_btn_stat          w_btn;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_long_press <= LONG_PRESS_RST;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_DEBOUNCE:   r_debounce   <= pwdata[CFG_W-1:0];
                REG_LONG_PRESS: r_long_press <= pwdata[CFG_W-1:0];
                default:        r_debounce   <= r_debounce;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_DEBOUNCE:   prdata = APB_DW'(r_debounce);
            REG_LONG_PRESS: prdata = APB_DW'(r_long_press);
            default:        prdata = '0;
        endcase
    end

    // pipeline: input register -> update logic -> result register
    assign w_move  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_a   <= i_pin_a;
            r_in_b   <= i_pin_b;
            r_in_btn <= i_button_level;
            r_in_now <= i_now_ms;
        end
        if (w_move) begin
            r_out_pos   <= w_pos;
            r_out_count <= w_btn.press_count;
            r_out_menu  <= w_btn.menu_flag;
            r_out_held  <= w_btn.held;
        end
    end

    qcb_btn u_btn (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_move),
        .i_button_level  (r_in_btn),
        .i_now_ms        (r_in_now),
        .i_debounce_ms   (r_debounce),
        .i_long_press_ms (r_long_press),
        .o_stat          (w_btn)
    );

    qcb_enc u_enc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_move),
        .i_pin_a    (r_in_a),
        .i_pin_b    (r_in_b),
        .i_clr      (w_btn.clr_pos),
        .o_position (w_pos)
    );

    assign o_valid       = r_out_valid;
    assign o_position    = r_out_pos;
    assign o_press_count = r_out_count;
    assign o_menu_flag   = r_out_menu;
    assign o_held        = r_out_held;

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_move) |=> r_in_valid)
        else $error("input register dropped a pending transaction");
    a_move_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid)
        else $error("result register empty after a move");
`endif

endmodule

// ----- verif/qcb_checker.sv -----
module qcb_checker
    import qcb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_ready,
    input  logic                i_pin_a,
    input  logic                i_pin_b,
    input  logic                i_button_level,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic                o_valid,
    input  logic                i_ready,
    input  logic [POS_W-1:0]    o_position,
    input  logic [COUNT_W-1:0]  o_press_count,
    input  logic                o_menu_flag,
    input  logic                o_held,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    input  logic                pready,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] press_count;
        logic               menu_flag;
        logic               held;
    } t_reading;

    t_reading           readings_due[$];

    logic               last_a;
    logic               last_b;
    logic               last_btn;
    logic               arm_a;
    logic               arm_b;
    logic               pressing;
    logic               menu;
    logic [POS_W-1:0]   ticks;
    logic [TIME_W-1:0]  accept_ms;
    logic [TIME_W-1:0]  press_ms;
    logic [COUNT_W-1:0] shorts;
    logic [CFG_W-1:0]   debounce;
    logic [CFG_W-1:0]   long_press;

    task automatic reset_tracker();
        debounce   = DEBOUNCE_RST;
        long_press = LONG_PRESS_RST;
        last_a     = 1'b1;
        last_b     = 1'b1;
        last_btn   = 1'b1;
        arm_a      = 1'b0;
        arm_b      = 1'b0;
        ticks      = '0;
        accept_ms  = '0;
        pressing   = 1'b0;
        press_ms   = '0;
        shorts     = '0;
        menu       = 1'b0;
    endtask

    task automatic track_sample(input logic a, input logic b, input logic btn,
                                input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] since;
        logic [TIME_W-1:0] hold;
        // A is decoded before B, both against the current levels
        if (a && !last_a) begin
            if (b && arm_a) begin
                if (ticks != '0) ticks = ticks - POS_W'(1);
                arm_a = 1'b0;
                arm_b = 1'b0;
            end else if (!b) begin
                arm_b = 1'b1;
            end
        end
        if (b && !last_b) begin
            if (a && arm_b) begin
                if (ticks != POS_MAX) ticks = ticks + POS_W'(1);
                arm_a = 1'b0;
                arm_b = 1'b0;
            end else if (!a) begin
                arm_a = 1'b1;
            end
        end
        last_a = a;
        last_b = b;
        if (btn != last_btn) begin
            since = t - accept_ms;
            if (since > TIME_W'(debounce)) begin
                if (!btn && !pressing) begin
                    pressing = 1'b1;
                    press_ms = t;
                end
                accept_ms = t;
            end
            // release ends a press even when the debounce test failed
            if (btn && pressing) begin
                hold = t - press_ms;
                if (hold >= TIME_W'(long_press)) begin
                    ticks = '0;
                end else begin
                    if (shorts != COUNT_MAX) shorts = shorts + COUNT_W'(1);
                    if (shorts >= MENU_PRESSES) menu = 1'b1;
                end
                pressing = 1'b0;
            end
        end
        last_btn = btn;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            reset_tracker();
            readings_due.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (readings_due.size() == 0) begin
                    $error("result transaction with no sample waiting");
                    o_fail_count++;
                end else begin
                    want = readings_due.pop_front();
                    compare_field("position", 32'(want.position), 32'(o_position));
                    compare_field("press_count", 32'(want.press_count),
                                  32'(o_press_count));
                    compare_field("menu_flag", 32'(want.menu_flag), 32'(o_menu_flag));
                    compare_field("held", 32'(want.held), 32'(o_held));
                    o_checked++;
                end
            end
            if (i_valid && o_ready) begin
                track_sample(i_pin_a, i_pin_b, i_button_level, i_now_ms);
                readings_due.push_back('{ticks, shorts, menu, pressing});
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[2]))
                    REG_DEBOUNCE:   debounce   = pwdata[CFG_W-1:0];
                    REG_LONG_PRESS: long_press = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = readings_due.size();
    end

endmodule

// ----- verif/tb.sv -----
module tb;
    import qcb_pkg::*;

    localparam int SEG_ITEMS   = 240;
    localparam int CYCLE_LIMIT = 2000000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_pin_a;
    logic                i_pin_b;
    logic                i_button_level;
    logic [TIME_W-1:0]   i_now_ms;
    logic                o_valid;
    logic                i_ready;
    logic [POS_W-1:0]    o_position;
    logic [COUNT_W-1:0]  o_press_count;
    logic                o_menu_flag;
    logic                o_held;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  checked;
    int                  n_sent;
    int                  n_writes;
    int                  n_cycles;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    logic [1:0]          enc_ph;
    logic                btn_lvl;
    logic [TIME_W-1:0]   ms;
    logic [CFG_W-1:0]    cfg_debounce;
    logic [CFG_W-1:0]    cfg_long;

    quadrature_counter_with_button dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pin_a        (i_pin_a),
        .i_pin_b        (i_pin_b),
        .i_button_level (i_button_level),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_position     (o_position),
        .o_press_count  (o_press_count),
        .o_menu_flag    (o_menu_flag),
        .o_held         (o_held),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    qcb_checker u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pin_a        (i_pin_a),
        .i_pin_b        (i_pin_b),
        .i_button_level (i_button_level),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_position     (o_position),
        .o_press_count  (o_press_count),
        .o_menu_flag    (o_menu_flag),
        .o_held         (o_held),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // entered and left just after a falling edge
    task automatic send(input logic a, input logic b, input logic btn,
                        input logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pin_a        <= a;
        i_pin_b        <= b;
        i_button_level <= btn;
        i_now_ms       <= t;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        n_sent++;
    endtask

    // gray phase 0..3 maps to AB = 00, 10, 11, 01
    task automatic put();
        send(enc_ph[0] ^ enc_ph[1], enc_ph[1], btn_lvl, ms);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= {16'($urandom_range(0, 65535)), val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DEBOUNCE) cfg_debounce = val;
        else cfg_long = val;
        n_writes++;
    endtask

    task automatic random_episode();
        int unsigned       kind;
        int unsigned       n;
        int unsigned       sel;
        logic              dir;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] hold;
        logic [TIME_W-1:0] t0;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            dir = 1'($urandom_range(0, 1));
            n   = $urandom_range(1, 12);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0) dir = ~dir;
                enc_ph = dir ? enc_ph + 2'd1 : enc_ph - 2'd1;
                ms += TIME_W'($urandom_range(0, 3));
                put();
            end
        end else if (kind <= 6) begin
            sel = $urandom_range(0, 3);
            case (sel)
                0:       gap = TIME_W'(cfg_debounce);
                1:       gap = TIME_W'(cfg_debounce) + TIME_W'(1);
                2:       gap = TIME_W'($urandom_range(0, 32'(cfg_debounce) + 2));
                default: gap = TIME_W'($urandom_range(0, 100000));
            endcase
            ms += gap;
            btn_lvl = 1'b0;
            put();
            t0 = ms;
            repeat ($urandom_range(0, 3)) begin
                enc_ph += 2'd1;
                put();
            end
            sel = $urandom_range(0, 5);
            case (sel)
                0:       hold = '0;
                1:       hold = TIME_W'(cfg_long) - TIME_W'(1);
                2:       hold = TIME_W'(cfg_long);
                3:       hold = TIME_W'(cfg_long) + TIME_W'(1);
                4:       hold = TIME_W'($urandom_range(0, 32'(cfg_long)));
                default: hold = $urandom;
            endcase
            ms = t0 + hold;
            btn_lvl = 1'b1;
            put();
        end else if (kind == 7) begin
            repeat ($urandom_range(2, 6)) begin
                btn_lvl = ~btn_lvl;
                ms += TIME_W'($urandom_range(0, 20));
                put();
            end
        end else if (kind == 8) begin
            enc_ph  = 2'($urandom_range(0, 3));
            btn_lvl = 1'($urandom_range(0, 1));
            ms      = $urandom;
            put();
        end else begin
            ms = $urandom;
            put();
        end
    endtask

    initial begin
        int seg_start;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_pin_a        = 1'b1;
        i_pin_b        = 1'b1;
        i_button_level = 1'b1;
        i_now_ms       = '0;
        i_ready        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 19;
        recv_idle_pct  = 84;
        cfg_debounce   = DEBOUNCE_RST;
        cfg_long       = LONG_PRESS_RST;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed samples with the reset settings
        send(1'b1, 1'b1, 1'b1, 32'd0);
        send(1'b0, 1'b0, 1'b1, 32'd1);
        send(1'b0, 1'b1, 1'b1, 32'd2);
        send(1'b1, 1'b1, 1'b1, 32'd3);       // reverse tick at zero: floor
        send(1'b0, 1'b0, 1'b1, 32'd4);
        send(1'b1, 1'b0, 1'b1, 32'd5);
        send(1'b1, 1'b1, 1'b1, 32'd6);       // forward tick
        send(1'b0, 1'b0, 1'b1, 32'd7);
        send(1'b0, 1'b1, 1'b1, 32'd8);
        send(1'b0, 1'b0, 1'b1, 32'd9);
        send(1'b1, 1'b1, 1'b1, 32'd10);      // both rise, A decoded first
        send(1'b1, 1'b1, 1'b0, 32'd50);      // press inside debounce window
        send(1'b1, 1'b1, 1'b1, 32'd60);
        send(1'b1, 1'b1, 1'b0, 32'd100);     // exactly at debounce: still rejected
        send(1'b1, 1'b1, 1'b1, 32'd100);
        send(1'b1, 1'b1, 1'b0, 32'd101);
        send(1'b1, 1'b1, 1'b1, 32'd150);     // release inside window still ends press
        send(1'b1, 1'b1, 1'b0, 32'd300);
        send(1'b1, 1'b1, 1'b1, 32'd3299);    // just short of long press
        send(1'b0, 1'b0, 1'b0, 32'd3500);
        send(1'b1, 1'b0, 1'b0, 32'd3600);
        send(1'b1, 1'b1, 1'b1, 32'd6500);    // tick and long press together: reset wins
        send(1'b1, 1'b1, 1'b0, 32'd6700);
        send(1'b1, 1'b1, 1'b1, 32'd6710);    // third short press sets menu
        send(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send(1'b1, 1'b1, 1'b1, 32'd5);       // hold across timestamp wrap
        enc_ph  = 2'd2;
        btn_lvl = 1'b1;
        ms      = 32'd5;

        for (int seg = 0; seg < 6; seg++) begin
            drain();
            case (seg)
                0: begin apb_write(REG_DEBOUNCE, 16'd20);    apb_write(REG_LONG_PRESS, 16'd500);   end
                1: begin apb_write(REG_DEBOUNCE, 16'd0);     apb_write(REG_LONG_PRESS, 16'd0);     end
                2: begin apb_write(REG_DEBOUNCE, 16'hFFFF);  apb_write(REG_LONG_PRESS, 16'hFFFF);  end
                3: begin apb_write(REG_DEBOUNCE, 16'd3);     apb_write(REG_LONG_PRESS, 16'd40);    end
                4: begin apb_write(REG_DEBOUNCE, 16'd100);   apb_write(REG_LONG_PRESS, 16'd3000);  end
                default: begin
                    apb_write(REG_DEBOUNCE, 16'($urandom_range(0, 65535)));
                    apb_write(REG_LONG_PRESS, 16'($urandom_range(0, 65535)));
                end
            endcase
            case (seg / 2)
                0:       begin send_idle_pct = 19; recv_idle_pct = 84; end
                1:       begin send_idle_pct = 84; recv_idle_pct = 19; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            seg_start = n_sent;
            while (n_sent - seg_start < SEG_ITEMS) random_episode();
        end

        // saturate the press count, then end on a long press
        drain();
        apb_write(REG_DEBOUNCE, 16'd0);
        apb_write(REG_LONG_PRESS, 16'd1000);
        enc_ph  = 2'd2;
        btn_lvl = 1'b1;
        put();
        repeat (260) begin
            ms += 1;
            btn_lvl = 1'b0;
            put();
            ms += 1;
            btn_lvl = 1'b1;
            put();
        end
        ms += 1;
        btn_lvl = 1'b0;
        put();
        ms += 1000;
        btn_lvl = 1'b1;
        put();

        drain();
        $display("Sent %0d samples and checked %0d results across %0d register writes;",
                 n_sent, checked, n_writes);
        $display("covered encoder floor, debounce edges, long and short presses, count saturation.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
